/* rtl/core/ttms_pkg.sv */
// shared constants, codes and types of the time text parser
package ttms_pkg;

    localparam int FIELD_BITS      = 32;
    localparam int FRACTION_DIGITS = 3;
    localparam int CH_BITS         = 16;
    localparam int MS_BITS         = 54;
    localparam int ERR_BITS        = 3;
    localparam int FRAC_BITS       = 10;
    localparam int FDIG_BITS       = 2;
    localparam int OUT_TDATA_BITS  = 64;

    localparam logic [CH_BITS-1:0] CH_TAB   = 16'd9;
    localparam logic [CH_BITS-1:0] CH_CR    = 16'd13;
    localparam logic [CH_BITS-1:0] CH_SPACE = 16'd32;
    localparam logic [CH_BITS-1:0] CH_DOT   = 16'd46;
    localparam logic [CH_BITS-1:0] CH_ZERO  = 16'd48;
    localparam logic [CH_BITS-1:0] CH_NINE  = 16'd57;
    localparam logic [CH_BITS-1:0] CH_COLON = 16'd58;

    localparam int SEC_PER_MIN = 60;
    localparam int MS_PER_SEC  = 1000;

    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK        = 3'd0,
        ERR_EMPTY     = 3'd1,
        ERR_PARTS     = 3'd2,
        ERR_SS        = 3'd3,
        ERR_MMSS      = 3'd4,
        ERR_MMSS_SEC  = 3'd5,
        ERR_HMS       = 3'd6,
        ERR_HMS_RANGE = 3'd7
    } err_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MIN,
        ST_SEC,
        ST_MS
    } state_t;

    typedef struct packed {
        logic take;
        logic step_min;
        logic step_sec;
        logic load_out;
    } dp_cmd_t;

endpackage

/* rtl/core/time_text_to_milliseconds.sv */
// top level of the time text to milliseconds parser
// Takes a time string one character per transfer (SS, MM:SS or HH:MM:SS, optional
// fraction of up to three digits on the last part, surrounding whitespace ignored)
// and gives one result per string, which ends on the transfer that carries s_tlast. Each
// character takes one clock while s_tready is high. After the last character the
// block runs the conversion sequence (hours to minutes, minutes to seconds, seconds
// to milliseconds, one constant multiply-add each) and holds s_tready low meanwhile;
// the last step waits for the result register to be free. The result register holds
// time_ms and the error code; time_ms is zero whenever the error code is nonzero.
module time_text_to_milliseconds (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ttms_pkg::CH_BITS-1:0]          s_tdata,  // ch
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ttms_pkg::OUT_TDATA_BITS-1:0]   m_tdata   // time_ms, error_code, zero pad
);
    import ttms_pkg::*;

    dp_cmd_t             cmd;
    logic [MS_BITS-1:0]  time_ms;
    err_t                error_code;

    ttms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ttms_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .ch         (s_tdata),
        .time_ms    (time_ms),
        .error_code (error_code)
    );

    assign m_tdata = {(OUT_TDATA_BITS-MS_BITS-ERR_BITS)'(0), error_code, time_ms};

`ifndef SYNTHESIS
    // no character is taken while a finished string is being converted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("character accepted during conversion");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[56:54] != ERR_OK) |-> (m_tdata[53:0] == '0))
        else $error("nonzero time with an error code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[63:57] == '0))
        else $error("result padding not zero");
`endif

endmodule

/* rtl/core/ttms_dp.sv */
// datapath: character parser registers, conversion accumulator and result register
module ttms_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ttms_pkg::dp_cmd_t              cmd,
    input  logic [ttms_pkg::CH_BITS-1:0]   ch,
    output logic [ttms_pkg::MS_BITS-1:0]   time_ms,
    output ttms_pkg::err_t                 error_code
);
    import ttms_pkg::*;

    logic                  started_reg, started_next;
    logic                  pend_reg, pend_next;
    logic [1:0]            colon_reg, colon_next;
    logic                  nonempty_reg, nonempty_next;
    logic [FIELD_BITS-1:0] fv_reg [3];
    logic [FIELD_BITS-1:0] fv_next [3];
    logic                  dot_reg, dot_next;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;
    logic [FDIG_BITS-1:0]  fdig_reg, fdig_next;
    logic                  bad_reg, bad_next;
    logic                  many_reg, many_next;

    logic [MS_BITS-1:0]    acc_reg, acc_next;
    logic [MS_BITS-1:0]    ms_reg, ms_next;
    err_t                  err_reg, err;

    logic                  is_space, is_digit;
    logic [3:0]            digit;
    logic [FIELD_BITS+3:0] cur_wide, fv_wide;
    logic [FRAC_BITS-1:0]  frac_ms;
    logic [MS_BITS-1:0]    h_sel, m_sel, s_sel;
    logic                  bad_final;

    assign is_space = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE;
    assign is_digit = ch >= CH_ZERO && ch <= CH_NINE;
    assign digit    = ch[3:0];
    assign cur_wide = {4'b0, fv_reg[colon_reg]};
    // value * 10 + digit, with four spare bits to see overflow
    assign fv_wide  = (cur_wide << 3) + (cur_wide << 1) + (FIELD_BITS+4)'(digit);

    // per-character parse update
    always_comb begin
        started_next  = started_reg;
        pend_next     = pend_reg;
        colon_next    = colon_reg;
        nonempty_next = nonempty_reg;
        fv_next       = fv_reg;
        dot_next      = dot_reg;
        frac_next     = frac_reg;
        fdig_next     = fdig_reg;
        bad_next      = bad_reg;
        many_next     = many_reg;
        if (cmd.load_out) begin
            started_next  = 1'b0;
            pend_next     = 1'b0;
            colon_next    = '0;
            nonempty_next = 1'b0;
            fv_next[0]    = '0;
            fv_next[1]    = '0;
            fv_next[2]    = '0;
            dot_next      = 1'b0;
            frac_next     = '0;
            fdig_next     = '0;
            bad_next      = 1'b0;
            many_next     = 1'b0;
        end else if (cmd.take) begin
            if (is_space) begin
                if (started_reg) begin
                    pend_next = 1'b1;
                end
            end else begin
                if (pend_reg) begin
                    bad_next = 1'b1;
                end
                pend_next    = 1'b0;
                started_next = 1'b1;
                if (!many_reg) begin
                    if (is_digit) begin
                        if (dot_reg) begin
                            if (fdig_reg >= FDIG_BITS'(FRACTION_DIGITS)) begin
                                bad_next = 1'b1;
                            end else begin
                                frac_next = FRAC_BITS'(frac_reg * 10'd10)
                                          + FRAC_BITS'(digit);
                                fdig_next = fdig_reg + 1'b1;
                            end
                        end else begin
                            if (|fv_wide[FIELD_BITS+3:FIELD_BITS]) begin
                                bad_next = 1'b1;
                            end else begin
                                fv_next[colon_reg] = fv_wide[FIELD_BITS-1:0];
                            end
                            nonempty_next = 1'b1;
                        end
                    end else if (ch == CH_COLON) begin
                        if (colon_reg >= 2'd2) begin
                            many_next = 1'b1;
                        end else begin
                            if (!nonempty_reg || dot_reg) begin
                                bad_next = 1'b1;
                            end
                            colon_next    = colon_reg + 1'b1;
                            nonempty_next = 1'b0;
                            dot_next      = 1'b0;
                            frac_next     = '0;
                            fdig_next     = '0;
                        end
                    end else if (ch == CH_DOT) begin
                        if (dot_reg || !nonempty_reg) begin
                            bad_next = 1'b1;
                        end
                        dot_next = 1'b1;
                    end else begin
                        bad_next = 1'b1;
                    end
                end
            end
        end
    end

    // fraction padded on the right to milliseconds
    always_comb begin
        frac_ms = '0;
        if (dot_reg) begin
            unique case (fdig_reg)
                2'd1:    frac_ms = FRAC_BITS'(frac_reg * 10'd100);
                2'd2:    frac_ms = FRAC_BITS'(frac_reg * 10'd10);
                default: frac_ms = frac_reg;
            endcase
        end
    end

    // part selection by form
    always_comb begin
        h_sel = '0;
        m_sel = '0;
        s_sel = '0;
        unique case (colon_reg)
            2'd0: begin
                s_sel = MS_BITS'(fv_reg[0]);
            end
            2'd1: begin
                m_sel = MS_BITS'(fv_reg[0]);
                s_sel = MS_BITS'(fv_reg[1]);
            end
            default: begin
                h_sel = MS_BITS'(fv_reg[0]);
                m_sel = MS_BITS'(fv_reg[1]);
                s_sel = MS_BITS'(fv_reg[2]);
            end
        endcase
    end

    assign bad_final = bad_reg || !nonempty_reg || (dot_reg && fdig_reg == '0);

    always_comb begin
        err = ERR_OK;
        priority if (!started_reg) begin
            err = ERR_EMPTY;
        end else if (many_reg) begin
            err = ERR_PARTS;
        end else if (colon_reg == 2'd0) begin
            if (bad_final) begin
                err = ERR_SS;
            end
        end else if (colon_reg == 2'd1) begin
            if (bad_final) begin
                err = ERR_MMSS;
            end else if (fv_reg[1] >= FIELD_BITS'(SEC_PER_MIN)) begin
                err = ERR_MMSS_SEC;
            end
        end else begin
            if (bad_final) begin
                err = ERR_HMS;
            end else if (fv_reg[1] >= FIELD_BITS'(SEC_PER_MIN)
                      || fv_reg[2] >= FIELD_BITS'(SEC_PER_MIN)) begin
                err = ERR_HMS_RANGE;
            end
        end
    end

    // hours -> minutes -> seconds -> milliseconds, one constant multiply per step
    always_comb begin
        acc_next = acc_reg;
        ms_next  = ms_reg;
        if (cmd.step_min) begin
            acc_next = h_sel * MS_BITS'(SEC_PER_MIN) + m_sel;
        end
        if (cmd.step_sec) begin
            acc_next = acc_reg * MS_BITS'(SEC_PER_MIN) + s_sel;
        end
        if (cmd.load_out) begin
            ms_next = (err == ERR_OK)
                    ? acc_reg * MS_BITS'(MS_PER_SEC) + MS_BITS'(frac_ms)
                    : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            colon_reg    <= '0;
            nonempty_reg <= 1'b0;
            fv_reg[0]    <= '0;
            fv_reg[1]    <= '0;
            fv_reg[2]    <= '0;
            dot_reg      <= 1'b0;
            frac_reg     <= '0;
            fdig_reg     <= '0;
            bad_reg      <= 1'b0;
            many_reg     <= 1'b0;
        end else begin
            started_reg  <= started_next;
            pend_reg     <= pend_next;
            colon_reg    <= colon_next;
            nonempty_reg <= nonempty_next;
            fv_reg       <= fv_next;
            dot_reg      <= dot_next;
            frac_reg     <= frac_next;
            fdig_reg     <= fdig_next;
            bad_reg      <= bad_next;
            many_reg     <= many_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        ms_reg  <= ms_next;
        if (cmd.load_out) begin
            err_reg <= err;
        end
    end

    assign time_ms    = ms_reg;
    assign error_code = err_reg;

endmodule

/* rtl/core/ttms_ctrl.sv */
// controller: character intake, conversion sequencing and result valid
module ttms_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ttms_pkg::dp_cmd_t   cmd
);
    import ttms_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN: state_next = ST_SEC;
            ST_SEC: state_next = ST_MS;
            ST_MS: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_RUN: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_MIN: cmd.step_min = 1'b1;
            ST_SEC: cmd.step_sec = 1'b1;
            ST_MS:  cmd.load_out = out_free;
            default: cmd = '0;
        endcase
        // result register is held until its transfer
        out_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
